@@ src/albc_pkg.sv @@
package albc_pkg;

  localparam int SENSOR_FULL_SCALE = 100;

  localparam int LEVEL_W     = 7;
  localparam int COUNT_W     = 8;
  localparam int WAIT_W      = 16;
  localparam int SAMPLE_W    = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef logic [LEVEL_W-1:0]  level_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [WAIT_W-1:0]   wait_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  localparam level_t LEVEL_MAX = 7'd100;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DUTY_FLOOR       = 3'd0,
    REG_DUTY_CEILING     = 3'd1,
    REG_CHANGE_THRESHOLD = 3'd2,
    REG_WINDOW_SAMPLES   = 3'd3,
    REG_NEEDED_HITS      = 3'd4,
    REG_BRIGHTEN_WAIT    = 3'd5,
    REG_DARKEN_WAIT      = 3'd6
  } cfg_reg_t;

  localparam level_t RST_DUTY_FLOOR       = 7'd5;
  localparam level_t RST_DUTY_CEILING     = 7'd100;
  localparam level_t RST_CHANGE_THRESHOLD = 7'd10;
  localparam count_t RST_WINDOW_SAMPLES   = 8'd10;
  localparam count_t RST_NEEDED_HITS      = 8'd3;
  localparam wait_t  RST_BRIGHTEN_WAIT    = 16'd3;
  localparam wait_t  RST_DARKEN_WAIT      = 16'd10;
  localparam level_t RST_LEVEL            = 7'd100;

endpackage

@@ src/albc_ifs.sv @@
interface albc_sample_if;
  logic              valid;
  logic              ready;
  logic              mode;
  albc_pkg::sample_t light_sample;

  modport source (output valid, output mode, output light_sample, input ready);
  modport sink   (input valid, input mode, input light_sample, output ready);
endinterface

interface albc_result_if;
  logic             valid;
  logic             ready;
  albc_pkg::level_t duty_level;
  logic             window_open;
  logic             ramping;

  modport source (output valid, output duty_level, output window_open, output ramping,
                  input ready);
  modport sink   (input valid, input duty_level, input window_open, input ramping,
                  output ready);
endinterface

interface albc_cfg_if;
  logic                 valid;
  logic                 ready;
  albc_pkg::cfg_index_t index;
  albc_pkg::cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/ambient_light_backlight_controller_core.sv @@
// Ambient-light backlight controller. Each word on the sample channel is either a light
// reading (mode 0) or a time tick (mode 1), and every word yields exactly one result word
// carrying the driven duty level and the window/ramp flags after that word. A new word is
// taken every cycle while sample ready is high, the pipeline depth being set by the level
// mapping, which scales the reading through two registered multiplications (span times
// reading, then a reciprocal of the full-scale constant) and a correction stage before the
// state update. Ready on the sample side only drops when the result register is held and
// every stage behind it is full. Registers are written on the configuration channel, which
// is always ready; write them only while no word is in flight.
module ambient_light_backlight_controller_core #(
  parameter int SensorFullScale = albc_pkg::SENSOR_FULL_SCALE
) (
  input  logic          clk,
  input  logic          rst,
  albc_sample_if.sink   sample,
  albc_result_if.source result,
  albc_cfg_if.sink      cfg
);
  import albc_pkg::*;

  localparam int ScaleW     = $clog2(SensorFullScale + 1);
  localparam int ProdW      = $clog2((2**LEVEL_W - 1) * SensorFullScale + 1);
  localparam int RecipShift = ProdW;
  localparam int RecipW     = RecipShift + 1;
  localparam int WideW      = ProdW + RecipW;
  localparam int Recip      = (1 << RecipShift) / SensorFullScale;

  localparam logic [SAMPLE_W-1:0] FULL_S = SAMPLE_W'(SensorFullScale);
  localparam logic [ProdW-1:0]    FULL_P = ProdW'(SensorFullScale);
  localparam logic [RecipW-1:0]   RECIP  = RecipW'(Recip);

  typedef enum logic [2:0] {
    PH_NORMAL = 3'b001,
    PH_WINDOW = 3'b010,
    PH_RAMP   = 3'b100
  } phase_t;

  level_t duty_floor, duty_ceiling, change_threshold;
  count_t window_samples, needed_hits;
  wait_t  brighten_wait, darken_wait;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_floor       <= RST_DUTY_FLOOR;
      duty_ceiling     <= RST_DUTY_CEILING;
      change_threshold <= RST_CHANGE_THRESHOLD;
      window_samples   <= RST_WINDOW_SAMPLES;
      needed_hits      <= RST_NEEDED_HITS;
      brighten_wait    <= RST_BRIGHTEN_WAIT;
      darken_wait      <= RST_DARKEN_WAIT;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        REG_DUTY_FLOOR:       duty_floor       <= cfg.data[LEVEL_W-1:0];
        REG_DUTY_CEILING:     duty_ceiling     <= cfg.data[LEVEL_W-1:0];
        REG_CHANGE_THRESHOLD: change_threshold <= cfg.data[LEVEL_W-1:0];
        REG_WINDOW_SAMPLES:   window_samples   <= cfg.data[COUNT_W-1:0];
        REG_NEEDED_HITS:      needed_hits      <= cfg.data[COUNT_W-1:0];
        REG_BRIGHTEN_WAIT:    brighten_wait    <= cfg.data[WAIT_W-1:0];
        REG_DARKEN_WAIT:      darken_wait      <= cfg.data[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic v1, v2, v3;
  logic adv4, rdy3, rdy2, rdy1;

  assign adv4 = !result.valid || result.ready;
  assign rdy3 = !v3 || adv4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign sample.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= sample.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (adv4) result.valid <= v3;
    end
  end

  // stage 1: clamp reading, span times reading
  logic [SAMPLE_W-2:0] sample_pos;
  logic [ScaleW-1:0]   scale_clamp;
  level_t              span_mag;
  logic [ProdW-1:0]    prod1, prod2;
  logic                mode1, mode2, mode3;
  logic                neg1, neg2;

  always_comb begin
    sample_pos = sample.light_sample[SAMPLE_W-2:0];
    if ({1'b0, sample_pos} > FULL_S) begin
      scale_clamp = FULL_S[ScaleW-1:0];
    end else begin
      scale_clamp = ScaleW'(sample_pos);
    end
    span_mag = (duty_ceiling >= duty_floor) ? duty_ceiling - duty_floor
                                            : duty_floor - duty_ceiling;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      mode1 <= sample.mode;
      neg1  <= sample.light_sample[SAMPLE_W-1];
      prod1 <= ProdW'(span_mag) * ProdW'(scale_clamp);
    end
  end

  // stage 2: quotient estimate by reciprocal, low by at most one
  logic [WideW-1:0] recip_prod;
  level_t           quot_est;

  assign recip_prod = WideW'(prod1) * WideW'(RECIP);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      mode2    <= mode1;
      neg2     <= neg1;
      prod2    <= prod1;
      quot_est <= LEVEL_W'(recip_prod >> RecipShift);
    end
  end

  // stage 3: correct quotient, offset from floor, saturate
  logic [ProdW-1:0] rem;
  level_t           quot;
  logic [LEVEL_W:0] level_sum;
  level_t           level3;

  always_comb begin
    rem  = prod2 - ProdW'(quot_est) * FULL_P;
    quot = (rem >= FULL_P) ? quot_est + 1'b1 : quot_est;
    if (neg2) begin
      level_sum = {1'b0, duty_floor};
    end else if (duty_ceiling < duty_floor) begin
      level_sum = {1'b0, duty_floor} - {1'b0, quot};
    end else begin
      level_sum = {1'b0, duty_floor} + {1'b0, quot};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      mode3  <= mode2;
      level3 <= (level_sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : level_sum[LEVEL_W-1:0];
    end
  end

  // stage 4: controller state and result word
  level_t level_now, level_now_next, level_goal, level_goal_next;
  phase_t phase, phase_next;
  count_t window_count, window_count_next, hit_count, hit_count_next;
  wait_t  tick_wait, tick_wait_next;

  level_t diff, level_step;
  logic   hit, up;
  wait_t  step_wait, tick_wait_inc;
  count_t window_count_inc, hit_count_inc;

  always_comb begin
    level_now_next    = level_now;
    level_goal_next   = level_goal;
    phase_next        = phase;
    window_count_next = window_count;
    hit_count_next    = hit_count;
    tick_wait_next    = tick_wait;

    diff = (level3 > level_now) ? level3 - level_now : level_now - level3;
    hit  = diff > change_threshold;
    up   = level_goal > level_now;
    step_wait = up ? brighten_wait : darken_wait;
    tick_wait_inc    = (tick_wait != '1) ? tick_wait + 1'b1 : tick_wait;
    window_count_inc = (window_count != '1) ? window_count + 1'b1 : window_count;
    hit_count_inc    = (hit_count != '1) ? hit_count + 1'b1 : hit_count;
    if (up) begin
      level_step = level_now + 1'b1;
    end else if (level_now > level_goal) begin
      level_step = level_now - 1'b1;
    end else begin
      level_step = level_now;
    end

    case (phase)
      PH_RAMP: begin
        if (mode3 == MODE_TICK) begin
          if (tick_wait_inc >= step_wait) begin
            tick_wait_next = '0;
            level_now_next = level_step;
            if (level_step == level_goal) phase_next = PH_NORMAL;
          end else begin
            tick_wait_next = tick_wait_inc;
          end
        end
      end
      PH_WINDOW: begin
        if (mode3 == MODE_SAMPLE) begin
          window_count_next = window_count_inc;
          if (hit) hit_count_next = hit_count_inc;
          if (hit && hit_count_inc >= needed_hits) begin
            level_goal_next = level3;
            tick_wait_next  = '0;
            phase_next      = PH_RAMP;
          end else if (window_count_inc >= window_samples) begin
            phase_next = PH_NORMAL;
          end
        end
      end
      default: begin
        if (mode3 == MODE_SAMPLE) begin
          if (hit) begin
            window_count_next = '0;
            hit_count_next    = '0;
            phase_next        = PH_WINDOW;
          end else begin
            phase_next = PH_NORMAL;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_now    <= RST_LEVEL;
      level_goal   <= RST_LEVEL;
      phase        <= PH_NORMAL;
      window_count <= '0;
      hit_count    <= '0;
      tick_wait    <= '0;
    end else if (adv4 && v3) begin
      level_now    <= level_now_next;
      level_goal   <= level_goal_next;
      phase        <= phase_next;
      window_count <= window_count_next;
      hit_count    <= hit_count_next;
      tick_wait    <= tick_wait_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4 && v3) begin
      result.duty_level  <= level_now_next;
      result.window_open <= (phase_next == PH_WINDOW);
      result.ramping     <= (phase_next == PH_RAMP);
    end
  end

endmodule

@@ src/albc_checker.sv @@
module albc_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input albc_pkg::level_t duty_level,
  input logic             window_open,
  input logic             ramping
);
  import albc_pkg::*;

  level_t prev_level;
  logic   prev_ramping;
  logic   have_prev;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (result_valid && result_ready) begin
      have_prev <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid && result_ready) begin
      prev_level   <= duty_level;
      prev_ramping <= ramping;
    end
  end

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> duty_level <= LEVEL_MAX)
    else $error("duty level above full scale");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(window_open && ramping))
    else $error("window and ramp flags both set");

  a_hold_outside_ramp: assert property (@(posedge clk) disable iff (rst)
    result_valid && have_prev && !prev_ramping |-> duty_level == prev_level)
    else $error("duty level moved outside a ramp");

  a_single_step: assert property (@(posedge clk) disable iff (rst)
    result_valid && have_prev |->
      (duty_level == prev_level) || (duty_level == prev_level + 1'b1) ||
      (duty_level + 1'b1 == prev_level))
    else $error("duty level moved by more than one step");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(duty_level))
    else $error("stalled result word not held");

endmodule

bind ambient_light_backlight_controller_core albc_checker u_albc_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .duty_level   (result.duty_level),
  .window_open  (result.window_open),
  .ramping      (result.ramping)
);
